FILE: hdl/hsc_pkg.sv
`timescale 1ns / 1ps

package hsc_pkg;

	// Slot address width of the physical store.
	localparam int TABLE_BITS  = 16;
	localparam int SLOT_COUNT  = 1 << TABLE_BITS;
	localparam int COUNT_W     = TABLE_BITS + 1;
	localparam int CFG_DATA_W  = 8;
	localparam int CFG_INDEX_W = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(SLOT_COUNT);

	typedef logic [TABLE_BITS-1:0] slot_t;
	typedef logic [COUNT_W-1:0]    count_t;

	// Request commands; the fourth code is unused and leaves the store alone.
	typedef enum logic [1:0] {
		CMD_STORE = 2'd0,
		CMD_PROBE = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_INDEX_BITS = 2'd0,
		REG_SEARCH_AGE = 2'd1,
		REG_EXACT_CODE = 2'd2
	} reg_index_t;

	// One slot: packed payload, check word (hash XOR payload) and age stamp.
	typedef struct packed {
		logic [63:0] payload;
		logic [63:0] check;
		logic [7:0]  age;
	} entry_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [63:0]        position_hash;
		logic [15:0]        move_code;
		logic [7:0]         search_depth;
		logic signed [31:0] score_value;
		logic [7:0]         bound_kind;
	} req_t;

	typedef struct packed {
		logic [7:0] search_age;
		logic [7:0] exact_code;
	} cfg_t;

	// Write-back decision for the slot under work.
	typedef struct packed {
		logic   we;
		entry_t wr;
	} wb_t;

	typedef struct packed {
		logic               hit;
		logic [15:0]        found_move;
		logic [7:0]         found_depth;
		logic signed [31:0] found_score;
		logic [7:0]         found_bound;
		logic               stored;
	} res_t;

	// Index mask for the configured width, saturated to 1..TABLE_BITS.
	function automatic slot_t slot_mask(input logic [4:0] index_bits);
		int unsigned b;
		slot_t       m;
		b = int'(index_bits);
		if (b < 1) begin
			b = 1;
		end
		if (b > TABLE_BITS) begin
			b = TABLE_BITS;
		end
		for (int k = 0; k < TABLE_BITS; k++) begin
			m[k] = (k < b);
		end
		return m;
	endfunction

endpackage

FILE: hdl/hsc_req_if.sv
`timescale 1ns / 1ps

interface hsc_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic [63:0]        position_hash;
	logic [15:0]        move_code;
	logic [7:0]         search_depth;
	logic signed [31:0] score_value;
	logic [7:0]         bound_kind;

	modport source (
		output valid, cmd, position_hash, move_code, search_depth, score_value, bound_kind,
		input  ready
	);
	modport sink (
		input  valid, cmd, position_hash, move_code, search_depth, score_value, bound_kind,
		output ready
	);
endinterface

FILE: hdl/hsc_rsp_if.sv
`timescale 1ns / 1ps

interface hsc_rsp_if;
	logic               valid;
	logic               ready;
	logic               hit;
	logic [15:0]        found_move;
	logic [7:0]         found_depth;
	logic signed [31:0] found_score;
	logic [7:0]         found_bound;
	logic               stored;
	logic [16:0]        valid_count;

	modport source (
		output valid, hit, found_move, found_depth, found_score, found_bound, stored,
		       valid_count,
		input  ready
	);
	modport sink (
		input  valid, hit, found_move, found_depth, found_score, found_bound, stored,
		       valid_count,
		output ready
	);
endinterface

FILE: hdl/hashed_search_cache.sv
`timescale 1ns / 1ps

// Direct-mapped cache of search results, addressed by the low bits of a 64-bit
// position hash. Requests arrive on req (valid/ready); each request gives
// exactly one response on rsp (valid/ready), in order. A store request writes
// the slot when the replacement rule allows it, a probe request reports the
// slot's fields when its check word matches, a clear request empties the slot.
// Every response carries the number of valid slots after that request.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while the block is idle, which the block itself does not enforce.
// Timing: a request first reads its slot from the single-port RAM, then
// writes the slot back and loads the response register; no new request is
// accepted until the request in work has finished. The response is
// visible the cycle after the write-back. While the response register is
// full and rsp.ready is low, the request in work holds its slot and no new
// request is taken.
// Reset: the slot RAM is swept to zero, one slot per cycle, after arst_n
// rises; req.ready stays low during the sweep.
// Configuration writes are taken at any time.
module hashed_search_cache (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [hsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [hsc_pkg::CFG_DATA_W-1:0]      cfg_data,
	hsc_req_if.sink                             req,
	hsc_rsp_if.source                           rsp
);

	// Configuration registers.
	logic [4:0] index_bits_q;
	logic [7:0] search_age_q;
	logic [7:0] exact_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q <= 5'd16;
			search_age_q <= 8'd0;
			exact_code_q <= 8'd0;
		end else if (cfg_we) begin
			case (hsc_pkg::reg_index_t'(cfg_index))
				hsc_pkg::REG_INDEX_BITS: index_bits_q <= cfg_data[4:0];
				hsc_pkg::REG_SEARCH_AGE: search_age_q <= cfg_data[7:0];
				hsc_pkg::REG_EXACT_CODE: exact_code_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Clearing sweep after reset.
	logic                  clr_busy_q;
	hsc_pkg::slot_t        clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Request stage: the request whose slot is being read and written back.
	logic            busy_s1;
	hsc_pkg::req_t   req_s1;
	hsc_pkg::slot_t  addr_s1;
	hsc_pkg::entry_t rd_s1;
	logic            accept;
	logic            finish;
	hsc_pkg::slot_t  in_addr;

	assign req.ready = !clr_busy_q && !busy_s1;
	assign accept    = req.valid && req.ready;
	assign finish    = busy_s1 && (!rsp.valid || rsp.ready);
	assign in_addr   = req.position_hash[hsc_pkg::TABLE_BITS-1:0]
	                 & hsc_pkg::slot_mask(index_bits_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (accept) begin
			busy_s1 <= 1'b1;
		end else if (finish) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.cmd           <= req.cmd;
			req_s1.position_hash <= req.position_hash;
			req_s1.move_code     <= req.move_code;
			req_s1.search_depth  <= req.search_depth;
			req_s1.score_value   <= req.score_value;
			req_s1.bound_kind    <= req.bound_kind;
			addr_s1              <= in_addr;
		end
	end

	// Decision logic for the request in work.
	hsc_pkg::cfg_t cfg;
	hsc_pkg::wb_t  wb;
	hsc_pkg::res_t res;

	assign cfg.search_age = search_age_q;
	assign cfg.exact_code = exact_code_q;

	hsc_policy u_policy (
		.req (req_s1),
		.cur (rd_s1),
		.cfg (cfg),
		.wb  (wb),
		.res (res)
	);

	// Single-port slot RAM. The port address follows the sweep, then the
	// request in work, else the incoming request; a write happens only in the
	// sweep or at the finishing edge, when no new request is read.
	hsc_pkg::entry_t mem [hsc_pkg::SLOT_COUNT];
	hsc_pkg::slot_t  mem_addr;
	logic            mem_we;
	hsc_pkg::entry_t mem_wdata;

	always_comb begin
		if (clr_busy_q) begin
			mem_addr  = clr_addr_q;
			mem_we    = 1'b1;
			mem_wdata = '0;
		end else if (busy_s1) begin
			mem_addr  = addr_s1;
			mem_we    = finish && wb.we;
			mem_wdata = wb.wr;
		end else begin
			mem_addr  = in_addr;
			mem_we    = 1'b0;
			mem_wdata = wb.wr;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rd_s1 <= mem[mem_addr];
	end

	// Running count of slots with a nonzero check word.
	hsc_pkg::count_t cnt_q;
	hsc_pkg::count_t cnt_next;
	logic            was_valid;
	logic            now_valid;

	assign was_valid = (rd_s1.check != 64'd0);
	assign now_valid = (wb.wr.check != 64'd0);

	always_comb begin
		cnt_next = cnt_q;
		if (wb.we && was_valid && !now_valid) begin
			cnt_next = cnt_q - 1'b1;
		end else if (wb.we && !was_valid && now_valid) begin
			cnt_next = cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (finish) begin
			cnt_q <= cnt_next;
		end
	end

	// Response register.
	logic rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp.hit         <= res.hit;
			rsp.found_move  <= res.found_move;
			rsp.found_depth <= res.found_depth;
			rsp.found_score <= res.found_score;
			rsp.found_bound <= res.found_bound;
			rsp.stored      <= res.stored;
			rsp.valid_count <= cnt_next;
		end
	end

	assign rsp.valid = rsp_valid_q;

	// The sweep and the request path never share the RAM port.
	a_no_req_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !req.ready)
		else $error("request accepted during clearing sweep");

	// A finished request always presents its response next cycle.
	a_finish_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> rsp.valid)
		else $error("finished request lost its response");

	// The valid-slot count never exceeds the store size.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= hsc_pkg::COUNT_MAX)
		else $error("valid count out of range");

	// The count moves by at most one per cycle, and only when a request finishes.
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(finish) |-> $stable(cnt_q))
		else $error("valid count changed without a request");

	a_cnt_delta: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + 1'b1)
		|| (cnt_q == $past(cnt_q) - 1'b1))
		else $error("valid count jumped");

endmodule

FILE: hdl/hsc_policy.sv
`timescale 1ns / 1ps

// Decides what a request does to the slot it addresses: replacement rule for
// stores, check word match for probes, emptying for clears.
module hsc_policy (
	input  hsc_pkg::req_t   req,
	input  hsc_pkg::entry_t cur,
	input  hsc_pkg::cfg_t   cfg,
	output hsc_pkg::wb_t    wb,
	output hsc_pkg::res_t   res
);

	logic [63:0] new_payload;
	logic [7:0]  cur_depth;
	logic [7:0]  cur_bound;
	logic        cur_valid;
	logic        replace;

	assign new_payload = {req.bound_kind, req.score_value, req.search_depth, req.move_code};
	assign cur_depth   = cur.payload[23:16];
	assign cur_bound   = cur.payload[63:56];
	assign cur_valid   = (cur.check != 64'd0);

	always_comb begin
		if (!cur_valid) begin
			replace = 1'b1;
		end else if (cur.age < cfg.search_age) begin
			replace = 1'b1;
		end else if (cur_depth < req.search_depth) begin
			replace = 1'b1;
		end else begin
			// Same position at equal depth: never let a bound overwrite an exact score.
			replace = ((cur.check ^ cur.payload) == req.position_hash)
			       && (cur_depth == req.search_depth)
			       && ((req.bound_kind == cfg.exact_code) || (cur_bound != cfg.exact_code));
		end
	end

	always_comb begin
		wb  = '0;
		res = '0;
		case (hsc_pkg::cmd_t'(req.cmd))
			hsc_pkg::CMD_STORE: begin
				wb.we         = replace;
				wb.wr.payload = new_payload;
				wb.wr.check   = req.position_hash ^ new_payload;
				wb.wr.age     = cfg.search_age;
				res.stored    = replace;
			end
			hsc_pkg::CMD_PROBE: begin
				if (cur_valid && ((req.position_hash ^ cur.payload) == cur.check)) begin
					res.hit         = 1'b1;
					res.found_move  = cur.payload[15:0];
					res.found_depth = cur.payload[23:16];
					res.found_score = cur.payload[55:24];
					res.found_bound = cur.payload[63:56];
				end
			end
			hsc_pkg::CMD_CLEAR: begin
				wb.we = 1'b1;
			end
			default: begin
				wb  = '0;
				res = '0;
			end
		endcase
	end

endmodule
